FILE: sv/ckp_pkg.sv
// ----------------------------------------------------------------------------
// ckp_pkg
// Shared types, constants and helper functions of the box keypoint projector.
// ----------------------------------------------------------------------------
package ckp_pkg;

    localparam int CORNER_COUNT = 8;
    localparam logic [3:0] LAST_INDEX = 4'(CORNER_COUNT);
    localparam int QBITS = 22;
    localparam int DIV_STAGES = QBITS + 1;
    localparam int IN_W = 216;
    localparam int OUT_W = 112;

    localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FOCAL_X      = 3'd2;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd3;
    localparam logic [2:0] REG_CENTER_X     = 3'd4;
    localparam logic [2:0] REG_CENTER_Y     = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd7;

    localparam logic signed [19:0] U_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] U_MIN = 20'sh80000;
    localparam logic signed [23:0] U_MAX24 = 24'sd524287;
    localparam logic signed [23:0] U_MIN24 = -24'sd524288;
    localparam logic signed [23:0] B_MAX24 = 24'sd32767;
    localparam logic signed [23:0] B_MIN24 = -24'sd32768;
    localparam logic signed [23:0] MARGIN16 = 24'sd320;

    typedef struct packed {
        logic [15:0] half_width;
        logic [15:0] half_height;
        logic [13:0] focal_x;
        logic [13:0] focal_y;
        logic [12:0] center_x;
        logic [12:0] center_y;
        logic [12:0] img_w;
        logic [12:0] img_h;
    } t_cfg;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [57:0] nu;
        logic signed [57:0] nv;
        logic signed [38:0] z;
    } t_num;

    typedef struct packed {
        logic [3:0] idx;
        logic       behind;
        logic       zf;
        logic       nsu;
        logic       posu;
        logic       negu;
        logic       nsv;
        logic       posv;
        logic       negv;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [38:0]      d;
        logic [57:0]      remu;
        logic [57:0]      remv;
        logic [QBITS-1:0] qu;
        logic [QBITS-1:0] qv;
        logic             ovfu;
        logic             ovfv;
    } t_dst;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic               behind;
        logic               last;
        logic signed [15:0] bx0;
        logic signed [15:0] by0;
        logic signed [15:0] bx1;
        logic signed [15:0] by1;
        logic               in_img;
    } t_res;

    function automatic logic signed [19:0] proj_fin(
        input logic             zf,
        input logic             pos,
        input logic             nsg,
        input logic             neg,
        input logic             ovf,
        input logic [QBITS-1:0] q,
        input logic             rnz,
        input logic [16:0]      off
    );
        logic signed [23:0] qs;
        logic signed [23:0] sm;
        logic signed [19:0] res;
        qs = neg ? (-$signed({2'd0, q}) - $signed({23'd0, rnz})) : $signed({2'd0, q});
        sm = qs + $signed({7'd0, off});
        if (zf) begin
            res = pos ? U_MAX : (nsg ? U_MIN : $signed({3'd0, off}));
        end else if (ovf) begin
            res = neg ? U_MIN : U_MAX;
        end else if (sm > U_MAX24) begin
            res = U_MAX;
        end else if (sm < U_MIN24) begin
            res = U_MIN;
        end else begin
            res = sm[19:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [23:0] a);
        logic signed [15:0] res;
        if (a > B_MAX24) begin
            res = 16'sh7FFF;
        end else if (a < B_MIN24) begin
            res = 16'sh8000;
        end else begin
            res = a[15:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/cuboid_keypoint_projector.sv
// ----------------------------------------------------------------------------
// cuboid_keypoint_projector
// Projects the eight corners and the center of a posed box, with bounding box.
// ----------------------------------------------------------------------------
// results follow one per cycle while the output is not stalled; nine results per
// pose, and the point sequencer takes the next pose while the center point of the
// last one is issued, feeding the single result channel
// a refused result moves to an output skid register, the pipeline holds until it drains
// synchronous active-low reset clears valid bits and loads register defaults
module cuboid_keypoint_projector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rot_00..rot_22 (16 each), trans_x, trans_y, trans_z (24 each)
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_u, point_v, behind_camera, box_x_min, box_y_min, box_x_max,
    // box_y_max, box_inside, zero fill
    output logic [111:0] m_tdata,
    output logic         m_tlast,
    // point_index
    output logic [3:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ckp_pkg::t_cfg r_cfg;
    logic          w_ce;
    logic          w_f_valid;
    ckp_pkg::t_num w_num;
    logic          w_d_valid;
    ckp_pkg::t_dst w_dst;
    logic          w_b_valid;
    ckp_pkg::t_res w_b_res;
    logic          r_sk_valid;
    ckp_pkg::t_res r_sk_res;
    ckp_pkg::t_res w_res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width   <= 16'd410;
            r_cfg.half_height  <= 16'd164;
            r_cfg.focal_x      <= 14'd700;
            r_cfg.focal_y      <= 14'd700;
            r_cfg.center_x     <= 13'd480;
            r_cfg.center_y     <= 13'd270;
            r_cfg.img_w        <= 13'd960;
            r_cfg.img_h        <= 13'd540;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                ckp_pkg::REG_HALF_WIDTH:   r_cfg.half_width   <= pwdata[15:0];
                ckp_pkg::REG_HALF_HEIGHT:  r_cfg.half_height  <= pwdata[15:0];
                ckp_pkg::REG_FOCAL_X:      r_cfg.focal_x      <= pwdata[13:0];
                ckp_pkg::REG_FOCAL_Y:      r_cfg.focal_y      <= pwdata[13:0];
                ckp_pkg::REG_CENTER_X:     r_cfg.center_x     <= pwdata[12:0];
                ckp_pkg::REG_CENTER_Y:     r_cfg.center_y     <= pwdata[12:0];
                ckp_pkg::REG_IMAGE_WIDTH:  r_cfg.img_w        <= pwdata[12:0];
                ckp_pkg::REG_IMAGE_HEIGHT: r_cfg.img_h        <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ckp_pkg::REG_HALF_WIDTH:   prdata = {16'd0, r_cfg.half_width};
            ckp_pkg::REG_HALF_HEIGHT:  prdata = {16'd0, r_cfg.half_height};
            ckp_pkg::REG_FOCAL_X:      prdata = {18'd0, r_cfg.focal_x};
            ckp_pkg::REG_FOCAL_Y:      prdata = {18'd0, r_cfg.focal_y};
            ckp_pkg::REG_CENTER_X:     prdata = {19'd0, r_cfg.center_x};
            ckp_pkg::REG_CENTER_Y:     prdata = {19'd0, r_cfg.center_y};
            ckp_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, r_cfg.img_w};
            ckp_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, r_cfg.img_h};
            default:                   prdata = 32'd0;
        endcase
    end

    assign w_ce = !r_sk_valid;

    ckp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .i_data  (s_tdata),
        .o_ready (s_tready),
        .o_valid (w_f_valid),
        .o_num   (w_num)
    );

    ckp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_f_valid),
        .i_num   (w_num),
        .o_valid (w_d_valid),
        .o_st    (w_dst)
    );

    ckp_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_cfg   (r_cfg),
        .i_valid (w_d_valid),
        .i_st    (w_dst),
        .o_valid (w_b_valid),
        .o_res   (w_b_res)
    );

    // output skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            if (m_tready) begin
                r_sk_valid <= 1'b0;
            end
        end else if (w_b_valid && !m_tready) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_valid) begin
            r_sk_res <= w_b_res;
        end
    end

    assign m_tvalid = r_sk_valid || w_b_valid;
    assign w_res    = r_sk_valid ? r_sk_res : w_b_res;

    assign m_tdata = {6'd0, w_res.in_img, w_res.by1, w_res.bx1, w_res.by0, w_res.bx0,
                      w_res.behind, w_res.v, w_res.u};
    assign m_tlast = w_res.last;
    assign m_tuser = w_res.idx;

`ifndef SYNTH
    a_no_take_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !r_sk_valid)
        else $error("pose taken while output stalled");

    a_last_is_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == ckp_pkg::LAST_INDEX)))
        else $error("tlast does not match center index");

    a_corner_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[105:41] == 65'd0))
        else $error("box fields set on corner result");

    a_index_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || m_tuser != 4'd0))
        else $error("corner run restarted early");
`endif

endmodule

FILE: sv/ckp_front.sv
// ----------------------------------------------------------------------------
// ckp_front
// Point sequencer, rotation products, corner sums and projection numerators.
// ----------------------------------------------------------------------------
module ckp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ce,
    input  ckp_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    input  logic [ckp_pkg::IN_W-1:0] i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output ckp_pkg::t_num          o_num
);

    logic signed [15:0] r_rot [0:8];
    logic signed [23:0] r_trn [0:2];
    logic [3:0]         r_idx;
    logic               r_busy;
    logic               w_last;
    logic signed [16:0] w_k [0:2];
    logic signed [16:0] w_hw;
    logic signed [16:0] w_hh;

    logic               r1_valid;
    logic [3:0]         r1_idx;
    logic signed [32:0] r1_prod [0:8];
    logic signed [23:0] r1_trn [0:2];

    logic               r2_valid;
    logic [3:0]         r2_idx;
    logic signed [38:0] r2_p [0:2];

    logic signed [18:0] w_fx;
    logic signed [18:0] w_fy;

    assign w_last  = r_idx == ckp_pkg::LAST_INDEX;
    assign o_ready = i_ce && (!r_busy || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (i_ce) begin
            if (i_valid && o_ready) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (r_busy && !w_last) begin
                r_idx <= r_idx + 4'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= i_data[16*k +: 16];
            end
            for (int k = 0; k < 3; k++) begin
                r_trn[k] <= i_data[144 + 24*k +: 24];
            end
        end
    end

    // corner sign order, zero offset for the center point
    always_comb begin
        w_hw = $signed({1'b0, i_cfg.half_width});
        w_hh = $signed({1'b0, i_cfg.half_height});
        if (w_last) begin
            w_k[0] = 17'sd0;
            w_k[1] = 17'sd0;
            w_k[2] = 17'sd0;
        end else begin
            w_k[0] = r_idx[2] ? -w_hw : w_hw;
            w_k[1] = r_idx[1] ? -w_hw : w_hw;
            w_k[2] = r_idx[0] ? -w_hh : w_hh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= r_busy;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    assign w_fx = $signed({1'b0, i_cfg.focal_x, 4'd0});
    assign w_fy = $signed({1'b0, i_cfg.focal_y, 4'd0});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_idx <= r_idx;
            for (int rw = 0; rw < 3; rw++) begin
                for (int cl = 0; cl < 3; cl++) begin
                    r1_prod[3*rw+cl] <= r_rot[3*rw+cl] * w_k[cl];
                end
                r1_trn[rw] <= r_trn[rw];
            end
            r2_idx <= r1_idx;
            for (int rw = 0; rw < 3; rw++) begin
                r2_p[rw] <= 39'(r1_prod[3*rw]) + 39'(r1_prod[3*rw+1])
                          + 39'(r1_prod[3*rw+2]) + 39'($signed({r1_trn[rw], 14'd0}));
            end
            o_num.idx <= r2_idx;
            o_num.nu  <= r2_p[0] * w_fx;
            o_num.nv  <= r2_p[1] * w_fy;
            o_num.z   <= r2_p[2];
        end
    end

endmodule

FILE: sv/ckp_div.sv
// ----------------------------------------------------------------------------
// ckp_div
// Pipelined restoring divider: an overflow stage, then one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module ckp_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  ckp_pkg::t_num i_num,
    output logic          o_valid,
    output ckp_pkg::t_dst o_st
);

    localparam int NS = ckp_pkg::DIV_STAGES;

    ckp_pkg::t_dst r_st  [0:NS];
    logic          r_vld [0:NS];
    ckp_pkg::t_dst w_prep;

    always_comb begin
        w_prep           = '0;
        w_prep.side.idx  = i_num.idx;
        w_prep.side.zf   = i_num.z == 39'sd0;
        w_prep.side.behind = i_num.z[38] || (i_num.z == 39'sd0);
        w_prep.side.nsu  = i_num.nu[57];
        w_prep.side.posu = !i_num.nu[57] && (i_num.nu != 58'sd0);
        w_prep.side.negu = i_num.nu[57] ^ i_num.z[38];
        w_prep.side.nsv  = i_num.nv[57];
        w_prep.side.posv = !i_num.nv[57] && (i_num.nv != 58'sd0);
        w_prep.side.negv = i_num.nv[57] ^ i_num.z[38];
        w_prep.d    = i_num.z[38] ? 39'(-i_num.z) : 39'(i_num.z);
        w_prep.remu = i_num.nu[57] ? 58'(-i_num.nu) : 58'(i_num.nu);
        w_prep.remv = i_num.nv[57] ? 58'(-i_num.nv) : 58'(i_num.nv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st[0] <= w_prep;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int B = ckp_pkg::QBITS - s;
        ckp_pkg::t_dst w_nx;
        logic [60:0]   w_dsh;
        logic          w_geu;
        logic          w_gev;

        always_comb begin
            w_nx  = r_st[s];
            w_dsh = {22'd0, r_st[s].d} << B;
            w_geu = {3'd0, r_st[s].remu} >= w_dsh;
            w_gev = {3'd0, r_st[s].remv} >= w_dsh;
            if (w_geu) begin
                w_nx.remu = r_st[s].remu - w_dsh[57:0];
            end
            if (w_gev) begin
                w_nx.remv = r_st[s].remv - w_dsh[57:0];
            end
        end

        if (s == 0) begin : g_ovf
            ckp_pkg::t_dst w_up;
            always_comb begin
                w_up      = w_nx;
                w_up.ovfu = w_geu;
                w_up.ovfv = w_gev;
            end
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[s+1] <= w_up;
                end
            end
        end else begin : g_bit
            ckp_pkg::t_dst w_up;
            always_comb begin
                w_up       = w_nx;
                w_up.qu[B] = w_geu;
                w_up.qv[B] = w_gev;
            end
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[s+1] <= w_up;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    assign o_valid = r_vld[NS];
    assign o_st    = r_st[NS];

endmodule

FILE: sv/ckp_box.sv
// ----------------------------------------------------------------------------
// ckp_box
// Final rounding and saturation, corner extent tracking, squared box output.
// ----------------------------------------------------------------------------
module ckp_box (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  ckp_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  ckp_pkg::t_dst i_st,
    output logic          o_valid,
    output ckp_pkg::t_res o_res
);

    logic               r_f_valid;
    logic [3:0]         r_f_idx;
    logic signed [19:0] r_f_u;
    logic signed [19:0] r_f_v;
    logic               r_f_behind;

    logic               r_g_valid;
    logic [3:0]         r_g_idx;
    logic signed [19:0] r_g_u;
    logic signed [19:0] r_g_v;
    logic               r_g_behind;

    logic signed [19:0] r_umin, r_umax, r_vmin, r_vmax;

    logic signed [23:0] w_xmn, w_xmx, w_ymn, w_ymx, w_xext, w_yext, w_w, w_s;
    logic               w_xmaj;
    logic signed [23:0] r_xmn, r_xmx, r_ymn, r_ymx, r_s;
    logic               r_xmaj;
    logic signed [23:0] w_bx0, w_by0, w_bx1, w_by1;
    logic signed [15:0] w_cx0, w_cy0, w_cx1, w_cy1;
    logic               w_in;
    logic               w_f_last;
    logic               w_g_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_ce) begin
            r_f_valid <= i_valid;
            r_g_valid <= r_f_valid;
            o_valid   <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_f_idx    <= i_st.side.idx;
            r_f_behind <= i_st.side.behind;
            r_f_u <= ckp_pkg::proj_fin(i_st.side.zf, i_st.side.posu, i_st.side.nsu,
                i_st.side.negu, i_st.ovfu, i_st.qu, |i_st.remu, {i_cfg.center_x, 4'd0});
            r_f_v <= ckp_pkg::proj_fin(i_st.side.zf, i_st.side.posv, i_st.side.nsv,
                i_st.side.negv, i_st.ovfv, i_st.qv, |i_st.remv, {i_cfg.center_y, 4'd0});
        end
    end

    assign w_f_last = r_f_idx == ckp_pkg::LAST_INDEX;
    assign w_g_last = r_g_idx == ckp_pkg::LAST_INDEX;

    // corner extent
    always_ff @(posedge i_clk) begin
        if (i_ce && r_f_valid && !w_f_last) begin
            if (r_f_idx == 4'd0) begin
                r_umin <= r_f_u;
                r_umax <= r_f_u;
                r_vmin <= r_f_v;
                r_vmax <= r_f_v;
            end else begin
                if (r_f_u < r_umin) r_umin <= r_f_u;
                if (r_f_u > r_umax) r_umax <= r_f_u;
                if (r_f_v < r_vmin) r_vmin <= r_f_v;
                if (r_f_v > r_vmax) r_vmax <= r_f_v;
            end
        end
    end

    // widened extent and half side of the square
    always_comb begin
        w_xmn  = 24'(r_umin) - ckp_pkg::MARGIN16;
        w_xmx  = 24'(r_umax) + ckp_pkg::MARGIN16;
        w_ymn  = 24'(r_vmin) - ckp_pkg::MARGIN16;
        w_ymx  = 24'(r_vmax) + ckp_pkg::MARGIN16;
        w_xext = w_xmx - w_xmn;
        w_yext = w_ymx - w_ymn;
        w_xmaj = w_xext > w_yext;
        w_w    = w_xmaj ? (w_xext / 24'sd16) : (w_yext / 24'sd16);
        w_s    = (w_w / 24'sd2) * 24'sd32;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_g_idx    <= r_f_idx;
            r_g_u      <= r_f_u;
            r_g_v      <= r_f_v;
            r_g_behind <= r_f_behind;
            r_xmn      <= w_xmn;
            r_xmx      <= w_xmx;
            r_ymn      <= w_ymn;
            r_ymx      <= w_ymx;
            r_s        <= w_s;
            r_xmaj     <= w_xmaj;
        end
    end

    always_comb begin
        if (r_xmaj) begin
            w_bx0 = r_xmn / 24'sd16;
            w_bx1 = r_xmx / 24'sd16;
            w_by0 = (r_ymx + r_ymn - r_s) / 24'sd32;
            w_by1 = (r_ymx + r_ymn + r_s) / 24'sd32;
        end else begin
            w_by0 = r_ymn / 24'sd16;
            w_by1 = r_ymx / 24'sd16;
            w_bx0 = (r_xmx + r_xmn - r_s) / 24'sd32;
            w_bx1 = (r_xmx + r_xmn + r_s) / 24'sd32;
        end
        w_cx0 = ckp_pkg::clamp16(w_bx0);
        w_cy0 = ckp_pkg::clamp16(w_by0);
        w_cx1 = ckp_pkg::clamp16(w_bx1);
        w_cy1 = ckp_pkg::clamp16(w_by1);
        w_in  = !w_cx0[15] && !w_cy0[15]
             && (17'(w_cx1) < $signed({4'd0, i_cfg.img_w}))
             && (17'(w_cy1) < $signed({4'd0, i_cfg.img_h}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_res.idx    <= r_g_idx;
            o_res.u      <= r_g_u;
            o_res.v      <= r_g_v;
            o_res.behind <= r_g_behind;
            o_res.last   <= w_g_last;
            o_res.bx0    <= w_g_last ? w_cx0 : 16'sd0;
            o_res.by0    <= w_g_last ? w_cy0 : 16'sd0;
            o_res.bx1    <= w_g_last ? w_cx1 : 16'sd0;
            o_res.by1    <= w_g_last ? w_cy1 : 16'sd0;
            o_res.in_img <= w_g_last && w_in;
        end
    end

endmodule
